@@ hw/rtl/presence_hold_and_range_average_top_defines.svh @@
`ifndef PRESENCE_HOLD_AND_RANGE_AVERAGE_TOP_DEFINES_SVH
`define PRESENCE_HOLD_AND_RANGE_AVERAGE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define PHA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define PHA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/pha_pkg.sv @@
package pha_pkg;

	localparam int HISTORY_MAX_DEF = 128;
	localparam int AVERAGE_MAX     = 100;
	localparam int HIST_RESET      = 100;
	localparam int AVG_RESET       = 10;

	localparam int HIST_CFG_W = 8;
	localparam int AVG_W      = 7;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int SAMPLE_W   = 16;
	localparam int SUM_W      = 23;
	localparam int REM_W      = AVG_W + 1;
	localparam int ITER_W     = $clog2(SUM_W);

	localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_LENGTH = 1'b1;

	localparam logic MODE_PRESENCE = 1'b0;
	localparam logic MODE_RANGE    = 1'b1;

	function automatic logic [AVG_W-1:0] clamp_avg(input logic [AVG_W-1:0] v);
		logic [AVG_W-1:0] r;
		if (v == '0) begin
			r = AVG_W'(1);
		end else if (v > AVG_W'(AVERAGE_MAX)) begin
			r = AVG_W'(AVERAGE_MAX);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/pha_if.sv @@
interface pha_in_if;
	import pha_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic                       present;
	logic signed [SAMPLE_W-1:0] range_value;

	modport source (output valid, mode, present, range_value, input ready);
	modport sink   (input valid, mode, present, range_value, output ready);
endinterface

interface pha_out_if;
	import pha_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       latest_reading;
	logic                       held_presence;
	logic signed [SAMPLE_W-1:0] range_average;
	logic                       average_new;

	modport source (output valid, latest_reading, held_presence, range_average, average_new,
		input ready);
	modport sink   (input valid, latest_reading, held_presence, range_average, average_new,
		output ready);
endinterface

@@ hw/rtl/presence_hold_and_range_average_top.sv @@
// Channel  | Dir | Payload                                                | Handshake
// in_ch    | in  | mode, present, range_value                             | valid/ready
// out_ch   | out | latest_reading, held_presence, range_average, average_new | valid/ready
// cfg      | in  | cfg_index, cfg_data                                    | cfg_we
// Presence reports and range reports that do not close a block: go to the output register.
// A range report that closes a block: bit-serial restoring divider, then the output register.
// One result register; in_ch.ready is high only when idle and that register is free or
// being transferred in the same cycle.
// arst_n resets all but the divider data registers at once; no clearing pass.
`include "presence_hold_and_range_average_top_defines.svh"

module presence_hold_and_range_average_top #(
	parameter int HISTORY_MAX = pha_pkg::HISTORY_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pha_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pha_pkg::CFG_DATA_W-1:0] cfg_data,
	pha_in_if.sink                         in_ch,
	pha_out_if.source                      out_ch
);
	import pha_pkg::*;

	localparam int RUN_W = $clog2(HISTORY_MAX + 1);
	localparam int CMP_W = (RUN_W > HIST_CFG_W) ? RUN_W : HIST_CFG_W;
	localparam logic [CMP_W-1:0] HIST_MAX_C = CMP_W'(HISTORY_MAX);
	localparam logic [CMP_W-1:0] HIST_RST   =
		(HISTORY_MAX < HIST_RESET) ? CMP_W'(HISTORY_MAX) : CMP_W'(HIST_RESET);
	localparam logic [RUN_W-1:0] RUN_SAT    = RUN_W'(HISTORY_MAX);

	typedef enum logic {ST_IDLE, ST_DIV} state_t;

	state_t                     state_q;
	logic [CMP_W-1:0]           hist_q;
	logic [AVG_W-1:0]           avg_len_q;
	logic                       last_q;
	logic                       held_q;
	logic [RUN_W-1:0]           run_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [AVG_W-1:0]           count_q;
	logic signed [SAMPLE_W-1:0] avg_q;
	logic                       out_valid_q;
	logic                       new_q;
	logic [ITER_W-1:0]          iter_q;

	logic [SUM_W-1:0] quo_q;
	logic [REM_W-1:0] rem_q;
	logic [AVG_W-1:0] divisor_q;
	logic             neg_q;

	logic                    accept;
	logic                    close_block;
	logic [RUN_W-1:0]        run_next;
	logic signed [SUM_W-1:0] sum_next;
	logic [AVG_W-1:0]        count_next;
	logic [SUM_W-1:0]        mag_next;
	logic [CMP_W-1:0]        hist_wr;
	logic [CMP_W-1:0]        hist_ext;
	logic [REM_W-1:0]        rem_shift;
	logic                    q_bit;
	logic [REM_W-1:0]        rem_next;
	logic [SUM_W-1:0]        quo_next;
	logic [SAMPLE_W-1:0]     quo_mag;
	logic                    div_last;

	assign accept   = in_ch.valid && in_ch.ready;
	assign div_last = (state_q == ST_DIV) && (iter_q == '0);

	assign in_ch.ready = (state_q == ST_IDLE) && (!out_valid_q || out_ch.ready);

	assign out_ch.valid          = out_valid_q;
	assign out_ch.latest_reading = last_q;
	assign out_ch.held_presence  = held_q;
	assign out_ch.range_average  = avg_q;
	assign out_ch.average_new    = new_q;

	assign run_next   = (run_q == RUN_SAT) ? run_q : run_q + RUN_W'(1);
	assign sum_next   = sum_q + SUM_W'(in_ch.range_value);
	assign count_next = count_q + AVG_W'(1);
	assign close_block = (count_next >= avg_len_q);
	assign mag_next   = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);

	assign hist_ext = CMP_W'(cfg_data);
	always_comb begin
		if (hist_ext == '0) begin
			hist_wr = CMP_W'(1);
		end else if (hist_ext > HIST_MAX_C) begin
			hist_wr = HIST_MAX_C;
		end else begin
			hist_wr = hist_ext;
		end
	end

	assign rem_shift = {rem_q[REM_W-2:0], quo_q[SUM_W-1]};
	assign q_bit     = (rem_shift >= REM_W'(divisor_q));
	assign rem_next  = q_bit ? (rem_shift - REM_W'(divisor_q)) : rem_shift;
	assign quo_next  = {quo_q[SUM_W-2:0], q_bit};
	assign quo_mag   = quo_next[SAMPLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hist_q      <= HIST_RST;
			avg_len_q   <= AVG_W'(AVG_RESET);
			last_q      <= 1'b0;
			held_q      <= 1'b0;
			run_q       <= RUN_SAT;
			sum_q       <= '0;
			count_q     <= '0;
			avg_q       <= '0;
			out_valid_q <= 1'b0;
			new_q       <= 1'b0;
			iter_q      <= '0;
		end else begin
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HISTORY_LENGTH: begin
						hist_q <= hist_wr;
						run_q  <= RUN_SAT;
						last_q <= 1'b0;
					end
					CFG_AVERAGE_LENGTH: begin
						avg_len_q <= clamp_avg(cfg_data[AVG_W-1:0]);
						sum_q     <= '0;
						count_q   <= '0;
					end
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_ch.mode == MODE_PRESENCE) begin
							last_q      <= in_ch.present;
							new_q       <= 1'b0;
							out_valid_q <= 1'b1;
							if (in_ch.present) begin
								run_q  <= '0;
								held_q <= 1'b1;
							end else begin
								run_q <= run_next;
								if (CMP_W'(run_next) >= hist_q) begin
									held_q <= 1'b0;
								end
							end
						end else if (close_block) begin
							sum_q   <= '0;
							count_q <= '0;
							iter_q  <= ITER_W'(SUM_W - 1);
							state_q <= ST_DIV;
						end else begin
							sum_q       <= sum_next;
							count_q     <= count_next;
							new_q       <= 1'b0;
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_DIV: begin
					iter_q <= iter_q - ITER_W'(1);
					if (div_last) begin
						avg_q       <= neg_q ? -$signed(quo_mag) : $signed(quo_mag);
						new_q       <= 1'b1;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// load the divider on block close, then shift one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (accept && (in_ch.mode == MODE_RANGE) && close_block) begin
			quo_q     <= mag_next;
			rem_q     <= '0;
			divisor_q <= count_next;
			neg_q     <= sum_next[SUM_W-1];
		end else if (state_q == ST_DIV) begin
			quo_q <= quo_next;
			rem_q <= rem_next;
		end
	end

	`PHA_ASSERT_NOW(a_no_take_in_div, state_q == ST_DIV, !in_ch.ready,
		"input taken while dividing")
	`PHA_ASSERT_NOW(a_run_bounded, 1'b1, run_q <= RUN_SAT,
		"off run beyond saturation")
	`PHA_ASSERT_NOW(a_count_below_len, state_q == ST_IDLE, count_q < avg_len_q,
		"block count reached length while idle")
	`PHA_ASSERT_NEXT(a_on_sets_held,
		accept && (in_ch.mode == MODE_PRESENCE) && in_ch.present, held_q && out_valid_q,
		"presence ON did not set held output")
	`PHA_ASSERT_NEXT(a_div_done_out, div_last, out_valid_q && new_q && (state_q == ST_IDLE),
		"division end did not present a new average")

endmodule
